// ----- rtl/met_pkg.sv -----
// Shared types and constants for the Mandelbrot escape-time pixel engine.
// Used by met_csr, met_ctrl, met_datapath and the top level; no dependencies.
package met_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int FRAC_BITS  = 28;

   localparam logic [2:0] REG_MAX_ITER   = 3'd0;
   localparam logic [2:0] REG_REAL_LEFT  = 3'd1;
   localparam logic [2:0] REG_IMAG_TOP   = 3'd2;
   localparam logic [2:0] REG_REAL_STEP  = 3'd3;
   localparam logic [2:0] REG_IMAG_STEP  = 3'd4;

   localparam logic [15:0] RST_MAX_ITER  = 16'd100;
   localparam logic [31:0] RST_REAL_LEFT = 32'hE000_0000;
   localparam logic [31:0] RST_IMAG_TOP  = 32'h2000_0000;
   localparam logic [30:0] RST_STEP      = 31'd1049601;

   localparam logic [31:0] COLOUR_BASE = 32'h000F_0F0F;
   localparam logic [31:0] COLOUR_STEP = 32'd1050;

   localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

   localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

   typedef struct packed {
      logic [15:0] max_iterations;
      logic [31:0] real_left;
      logic [31:0] imag_top;
      logic [30:0] real_step;
      logic [30:0] imag_step;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_MUL,
      ST_MAP_ADD,
      ST_SQUARE,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic map_mul;
      logic map_add;
      logic square;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic at_limit;
      logic last_step;
      logic escape;
   } status_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > SAT_HI) begin
         r = 32'h7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/met_csr.sv -----
// Configuration register file with an APB-style access port.
// Depends on met_pkg for register indexes, reset values and cfg_type.
module met_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [met_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [met_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [met_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output met_pkg::cfg_type               cfg
);

   met_pkg::cfg_type cfg_ff;
   met_pkg::cfg_type cfg_in;
   logic [2:0]       reg_idx;
   logic             wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            met_pkg::REG_MAX_ITER:  cfg_in.max_iterations = pwdata[15:0];
            met_pkg::REG_REAL_LEFT: cfg_in.real_left      = pwdata;
            met_pkg::REG_IMAG_TOP:  cfg_in.imag_top       = pwdata;
            met_pkg::REG_REAL_STEP: cfg_in.real_step      = pwdata[30:0];
            met_pkg::REG_IMAG_STEP: cfg_in.imag_step      = pwdata[30:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         met_pkg::REG_MAX_ITER:  prdata = {16'b0, cfg_ff.max_iterations};
         met_pkg::REG_REAL_LEFT: prdata = cfg_ff.real_left;
         met_pkg::REG_IMAG_TOP:  prdata = cfg_ff.imag_top;
         met_pkg::REG_REAL_STEP: prdata = {1'b0, cfg_ff.real_step};
         met_pkg::REG_IMAG_STEP: prdata = {1'b0, cfg_ff.imag_step};
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iterations <= met_pkg::RST_MAX_ITER;
         cfg_ff.real_left      <= met_pkg::RST_REAL_LEFT;
         cfg_ff.imag_top       <= met_pkg::RST_IMAG_TOP;
         cfg_ff.real_step      <= met_pkg::RST_STEP;
         cfg_ff.imag_step      <= met_pkg::RST_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/met_ctrl.sv -----
// Sequencing state machine for one pixel: map, then square/update loop.
// Depends on met_pkg for state_type, cmd_type and status_type.
module met_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  met_pkg::status_type  status,
   output met_pkg::cmd_type     cmd,
   output logic                 busy,
   output logic                 done
);

   met_pkg::state_type state_ff;
   met_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= met_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      done     = 1'b0;
      unique case (state_ff)
         met_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = met_pkg::ST_MAP_MUL;
            end
         end
         met_pkg::ST_MAP_MUL: begin
            cmd.map_mul = 1'b1;
            state_in    = met_pkg::ST_MAP_ADD;
         end
         met_pkg::ST_MAP_ADD: begin
            cmd.map_add = 1'b1;
            state_in    = status.at_limit ? met_pkg::ST_DONE : met_pkg::ST_SQUARE;
         end
         met_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = met_pkg::ST_UPDATE;
         end
         met_pkg::ST_UPDATE: begin
            priority if (status.escape) begin
               state_in = met_pkg::ST_DONE;
            end else if (status.last_step) begin
               cmd.step = 1'b1;
               state_in = met_pkg::ST_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = met_pkg::ST_SQUARE;
            end
         end
         met_pkg::ST_DONE: begin
            done     = 1'b1;
            state_in = met_pkg::ST_IDLE;
         end
         default: begin
            state_in = met_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/met_datapath.sv -----
// Point mapping, Q4.28 iteration registers, squares and escape test.
// Depends on met_pkg for cfg_type, cmd_type, status_type and sat32.
module met_datapath #(
   parameter int FRAME_WIDTH  = 1024,
   parameter int FRAME_HEIGHT = 1024,
   parameter int COUNT_BITS   = 16
) (
   input  logic                 clock,
   input  met_pkg::cfg_type     cfg,
   input  met_pkg::cmd_type     cmd,
   input  logic [9:0]           pixel_col,
   input  logic [9:0]           pixel_row,
   output met_pkg::status_type  status,
   output logic [15:0]          iteration_count,
   output logic [31:0]          pixel_colour
);

   localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;
   localparam logic [15:0] LimitCap = 16'((1 << CNT_W) - 1);
   localparam logic [11:0] ColLast  = 12'(FRAME_WIDTH - 1);
   localparam logic [11:0] RowLast  = 12'(FRAME_HEIGHT - 1);

   logic [9:0]          col_ff, row_ff;
   logic [CNT_W-1:0]    limit_ff, count_ff;
   logic [31:0]         colour_ff;
   logic [40:0]         map_re_ff, map_im_ff;
   logic signed [31:0]  c_re_ff, c_im_ff, z_re_ff, z_im_ff;
   logic signed [63:0]  sq_re_ff, sq_im_ff, cross_ff;

   logic [9:0]          col_in, row_in;
   logic [CNT_W-1:0]    limit_in;
   logic [40:0]         map_re_in, map_im_in;
   logic signed [63:0]  map_re_sum, map_im_sum;
   logic signed [63:0]  sq_re_in, sq_im_in, cross_in;
   logic signed [63:0]  diff, next_re, next_im;
   logic [63:0]         mag_sum;
   logic [CNT_W:0]      count_inc;

   assign col_in = ({2'b0, pixel_col} > ColLast) ? ColLast[9:0] : pixel_col;
   assign row_in = ({2'b0, pixel_row} > RowLast) ? RowLast[9:0] : pixel_row;
   assign limit_in = (cfg.max_iterations > LimitCap) ? LimitCap[CNT_W-1:0]
                                                     : cfg.max_iterations[CNT_W-1:0];

   assign map_re_in  = 41'(col_ff) * 41'(cfg.real_step);
   assign map_im_in  = 41'(row_ff) * 41'(cfg.imag_step);
   assign map_re_sum = 64'($signed(cfg.real_left)) + $signed({23'b0, map_re_ff});
   assign map_im_sum = 64'($signed(cfg.imag_top)) - $signed({23'b0, map_im_ff});

   assign sq_re_in = 64'(z_re_ff) * 64'(z_re_ff);
   assign sq_im_in = 64'(z_im_ff) * 64'(z_im_ff);
   assign cross_in = 64'(z_re_ff) * 64'(z_im_ff);

   assign mag_sum = $unsigned(sq_re_ff) + $unsigned(sq_im_ff);
   assign diff    = sq_re_ff - sq_im_ff;
   assign next_re = (diff >>> met_pkg::FRAC_BITS) + 64'(c_re_ff);
   assign next_im = (cross_ff >>> (met_pkg::FRAC_BITS - 1)) + 64'(c_im_ff);

   assign count_inc = {1'b0, count_ff} + {{CNT_W{1'b0}}, 1'b1};

   assign status.at_limit  = (count_ff == limit_ff);
   assign status.last_step = (count_inc == {1'b0, limit_ff});
   assign status.escape    = (mag_sum > met_pkg::ESCAPE_LIMIT);

   assign iteration_count = 16'(count_ff);
   assign pixel_colour    = colour_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         limit_ff  <= limit_in;
         count_ff  <= '0;
         colour_ff <= met_pkg::COLOUR_BASE;
      end
      if (cmd.map_mul) begin
         map_re_ff <= map_re_in;
         map_im_ff <= map_im_in;
      end
      if (cmd.map_add) begin
         c_re_ff <= met_pkg::sat32(map_re_sum);
         c_im_ff <= met_pkg::sat32(map_im_sum);
         z_re_ff <= met_pkg::sat32(map_re_sum);
         z_im_ff <= met_pkg::sat32(map_im_sum);
      end
      if (cmd.square) begin
         sq_re_ff <= sq_re_in;
         sq_im_ff <= sq_im_in;
         cross_ff <= cross_in;
      end
      if (cmd.step) begin
         z_re_ff   <= met_pkg::sat32(next_re);
         z_im_ff   <= met_pkg::sat32(next_im);
         count_ff  <= count_inc[CNT_W-1:0];
         colour_ff <= colour_ff + met_pkg::COLOUR_STEP;
      end
   end

endmodule

// ----- rtl/mandelbrot_escape_time_pixel_top.sv -----
// Top level of the Mandelbrot escape-time pixel engine.
// Instantiates met_csr, met_ctrl and met_datapath; depends on met_pkg.
//
//   channel  ports                                   handshake
//   request  req_pixel_col, req_pixel_row            start high while busy low
//   result   rsp_iteration_count, rsp_pixel_colour   rsp_valid, one cycle
//   config   psel penable pwrite paddr pwdata prdata pready (always ready)
//
// A pixel runs from accept through the map multiply and map add states, then k
// square/update passes (iterations done, plus one when the point escapes).
// Each pass runs the three 32x32 multipliers in the square state, then the update.
// busy is still low in the accept cycle, then stays high through the result cycle.
// Reset is synchronous and returns the controller to idle and the configuration
// registers to their defaults; results go out without backpressure.
module mandelbrot_escape_time_pixel_top #(
   parameter int FRAME_WIDTH  = 1024,
   parameter int FRAME_HEIGHT = 1024,
   parameter int COUNT_BITS   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [9:0]                     req_pixel_col,
   input  logic [9:0]                     req_pixel_row,
   output logic                           rsp_valid,
   output logic [15:0]                    rsp_iteration_count,
   output logic [31:0]                    rsp_pixel_colour,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [met_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [met_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [met_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   met_pkg::cfg_type    cfg;
   met_pkg::cmd_type    cmd;
   met_pkg::status_type status;

   met_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   met_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_valid)
   );

   met_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .COUNT_BITS   (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .cfg             (cfg),
      .cmd             (cmd),
      .pixel_col       (req_pixel_col),
      .pixel_row       (req_pixel_row),
      .status          (status),
      .iteration_count (rsp_iteration_count),
      .pixel_colour    (rsp_pixel_colour)
   );

endmodule

// ----- rtl/met_checker.sv -----
// Port-level checks of the pixel engine's command handshake, bound to the top.
// Depends only on the top level's ports.
module met_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   ast_word_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result word outside busy window");

   ast_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   ast_word_single_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result word not followed by idle");

   ast_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> (!busy && !rsp_valid))
      else $error("engine left idle without a command");

endmodule

bind mandelbrot_escape_time_pixel_top met_checker u_met_checker (.*);
